// ----- rtl/core/spq_pkg.sv -----
// Package for the sorted priority queue: sizes, codes, payload and memory port types.
package spq_pkg;

  // Storage geometry.
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned DATA_W = 32;

  // Field widths fixed by the interface.
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned CAP_W    = 5;

  // Configuration port.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Operation codes.
  localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // Value returned when the queue is empty.
  localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

  // Input transaction.
  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  // Output transaction.
  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [STATUS_W-1:0]      status;
    logic [CNT_W-1:0]         count;
  } out_item_t;

  // Request from the sequencer to the slot memory.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  // Physical slot of a logical position in the circular buffer.
  function automatic logic [IDX_W-1:0] slot_addr(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] offs);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ----- rtl/core/spq_ram.sv -----
// Slot memory: one write port and one registered read port.
module spq_ram (
  input  logic              clk_i,
  input  spq_pkg::mem_req_t req_i,
  output logic [spq_pkg::DATA_W-1:0] rdata_o
);
  import spq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/spq_cfg.sv -----
// Configuration register file behind the APB-style port.
module spq_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spq_pkg::PADDR_W-1:0] paddr,
  input  logic [spq_pkg::PDATA_W-1:0] pwdata,
  output logic [spq_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [spq_pkg::CAP_W-1:0]   cap_o
);
  import spq_pkg::*;

  logic             cap_sel;
  logic             wr_en;
  logic [CAP_W-1:0] cap_q;
  logic [CAP_W-1:0] cap_d;

  // Only one register exists, seen at addresses 0 to 3; addresses 4 and up are ignored.
  assign cap_sel = ~paddr[PADDR_W-1];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready & cap_sel;

  always_comb begin
    cap_d = cap_q;
    if (wr_en) begin
      cap_d = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  // Read data.
  assign prdata = cap_sel ? {{(PDATA_W-CAP_W){1'b0}}, cap_q} : '0;
  assign cap_o  = cap_q;

endmodule

// ----- rtl/core/spq_ctrl.sv -----
// Sequencer: decodes each operation and walks the slot memory for it.
module spq_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  spq_pkg::in_item_t          in_data_i,
  input  logic [spq_pkg::CAP_W-1:0]  cap_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output spq_pkg::out_item_t         res_data_o,
  output spq_pkg::mem_req_t          mem_req_o,
  input  logic [spq_pkg::DATA_W-1:0] mem_rdata_i
);
  import spq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_PLACE = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    head_q, head_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    pos_q, pos_d;
  logic [DATA_W-1:0]   val_q, val_d;
  logic                is_deq_q, is_deq_d;
  logic [DATA_W-1:0]   res_value_q, res_value_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [CNT_W-1:0]    cap_eff;
  logic                in_acc;

  // Capacity above the storage depth saturates at the depth.
  assign cap_eff = (cap_i > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_i;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & (state_q == S_IDLE);

  // Next-state and memory request logic.
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    pos_d        = pos_q;
    val_d        = val_q;
    is_deq_d     = is_deq_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    mem_req_o    = '{we: 1'b0, waddr: head_q, wdata: val_q, re: 1'b0, raddr: head_q};
    res_valid_o  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_value_d  = '0;
          res_status_d = STATUS_OK;
          case (in_data_i.kind) inside
            KIND_ENQ: begin
              if (count_q >= cap_eff) begin
                res_status_d = STATUS_FULL;
                state_d      = S_RESP;
              end else if (count_q == '0) begin
                // Empty queue: the value goes straight to the head slot.
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = head_q;
                mem_req_o.wdata = in_data_i.value;
                count_d         = CNT_W'(1);
                state_d         = S_RESP;
              end else begin
                // Start the insertion walk from the tail.
                val_d           = in_data_i.value;
                pos_d           = IDX_W'(count_q);
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = slot_addr(head_q, IDX_W'(count_q - CNT_W'(1)));
                state_d         = S_SHIFT;
              end
            end
            KIND_DEQ, KIND_PEEK: begin
              if (count_q == '0) begin
                res_value_d  = EMPTY_VALUE;
                res_status_d = STATUS_EMPTY;
                state_d      = S_RESP;
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = head_q;
                is_deq_d        = (in_data_i.kind == KIND_DEQ);
                state_d         = S_READ;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_READ: begin
        // Head entry has arrived; a dequeue advances the head.
        res_value_d = mem_rdata_i;
        if (is_deq_q) begin
          head_d  = slot_addr(head_q, IDX_W'(1));
          count_d = count_q - CNT_W'(1);
        end
        state_d = S_RESP;
      end

      S_SHIFT: begin
        if ($signed(mem_rdata_i) > $signed(val_q)) begin
          // Move the larger entry up one slot and look at the next one down.
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = slot_addr(head_q, pos_q);
          mem_req_o.wdata = mem_rdata_i;
          pos_d           = pos_q - IDX_W'(1);
          if (pos_q == IDX_W'(1)) begin
            state_d = S_PLACE;
          end else begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = slot_addr(head_q, pos_q - IDX_W'(2));
          end
        end else begin
          // Found an entry not greater: the new value goes just above it.
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = slot_addr(head_q, pos_q);
          mem_req_o.wdata = val_q;
          count_d         = count_q + CNT_W'(1);
          state_d         = S_RESP;
        end
      end

      S_PLACE: begin
        // Every entry was larger: the new value becomes the head.
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = head_q;
        mem_req_o.wdata = val_q;
        count_d         = count_q + CNT_W'(1);
        state_d         = S_RESP;
      end

      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    val_q        <= val_d;
    is_deq_q     <= is_deq_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
  end

  assign res_data_o = '{result_value: res_value_q, status: res_status_q, count: count_q};

endmodule

// ----- rtl/core/sorted_priority_queue.sv -----
// Top level of the sorted min-priority queue with its output register and checks.
//
//  Channel   Direction  Handshake                 Payload
//  in        input      in_valid_i / in_stall_o   in_data_i  (kind, value)
//  out       output     out_valid_o / out_stall_i out_data_o (result_value, status, count)
//  cfg       input      psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// One transaction is worked at a time. A dequeue or peek of a nonempty queue takes the
// head in S_READ; an enqueue into one walks down from the tail in S_SHIFT, moving each
// larger entry up, and writes the head in S_PLACE if all were larger; the rest go
// straight to S_RESP, where every operation ends. The walk does one read-compare-write
// step per cycle on the slot memory. Reset empties the queue and sets the capacity to 16.
// The output register frees the sequencer, so a new transaction is taken while a result
// waits under out_stall_i; a second finished result holds the sequencer until it drains.
module sorted_priority_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  spq_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output spq_pkg::out_item_t          out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spq_pkg::PADDR_W-1:0] paddr,
  input  logic [spq_pkg::PDATA_W-1:0] pwdata,
  output logic [spq_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import spq_pkg::*;

  logic [CAP_W-1:0]  cap;
  logic              res_valid;
  logic              res_ready;
  out_item_t         res_data;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_data_q, out_data_d;

  spq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap_o   (cap)
  );

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cap_i       (cap),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  spq_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Output register: loads when empty or draining this cycle.
  assign res_ready = ~out_valid_q | ~out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = res_data;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A finished result always lands in the output register.
  a_res_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> (out_valid_o && (out_data_o == $past(res_data))))
    else $error("result from sequencer not captured by output register");

  // One transaction at a time: the input stalls right after an accept.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while previous transaction still in work");

  // A capacity write takes effect at the next edge.
  a_cap_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && !paddr[PADDR_W-1])
      |=> (cap == $past(pwdata[CAP_W-1:0])))
    else $error("capacity register not updated by write");

  // An empty result always reports zero entries and the all-ones value.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && (res_data.status == STATUS_EMPTY))
      |-> ((res_data.count == '0) && (res_data.result_value == EMPTY_VALUE)))
    else $error("empty status with nonzero count or wrong value");

endmodule

// ----- sim/sorted_priority_queue_tb.sv -----
// Self-checking testbench for the sorted min-priority queue: directed, random and stall tests.
module sorted_priority_queue_tb;
  import spq_pkg::*;

  // Unused operation code; the queue must answer it without changing state.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Register map: the capacity register, and address 4, which has no register and must be ignored.
  localparam logic [PADDR_W-1:0] CAP_ADDR    = PADDR_W'(0);
  localparam logic [PADDR_W-1:0] UNUSED_ADDR = PADDR_W'(4);

  // Run control.
  localparam int CHUNK_ITEMS    = 80;
  localparam int HOLD_CYCLES    = 150;
  localparam int FLOOD_ITEMS    = 40;
  localparam int SETTLE_CYCLES  = 30;
  localparam int WATCHDOG_LIMIT = 2000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  in_item_t           in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_item_t          out_data_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  sorted_priority_queue uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // Predicted queue contents, kept sorted, and the capacity as last written.
  logic signed [DATA_W-1:0] sorted_slots [DEPTH];
  int unsigned              held_count;
  logic [CAP_W-1:0]         capacity_reg;

  // Results predicted for accepted transactions, oldest first.
  out_item_t pending_results[$];

  int error_count;
  int ops_sent;
  int results_seen;
  int full_seen;
  int empty_seen;
  int sender_idle_pct;
  int recv_stall_pct;
  int holds_asked;
  int holds_done;
  int hold_left;
  int quiet_cycles;

  // Apply one operation to the predicted queue and return the result it must produce.
  function automatic out_item_t apply_queue_op(input in_item_t op);
    out_item_t   res;
    int unsigned limit;
    int unsigned pos;
    res = '{result_value: '0, status: STATUS_OK, count: '0};
    limit = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
    case (op.kind)
      KIND_ENQ: begin
        if (held_count >= limit) begin
          res.status = STATUS_FULL;
          full_seen++;
        end else begin
          // Equal values stay ahead of the new one, so they leave in arrival order.
          pos = held_count;
          while (pos > 0 && sorted_slots[pos-1] > op.value) begin
            sorted_slots[pos] = sorted_slots[pos-1];
            pos--;
          end
          sorted_slots[pos] = op.value;
          held_count++;
        end
      end
      KIND_DEQ, KIND_PEEK: begin
        if (held_count == 0) begin
          res.result_value = EMPTY_VALUE;
          res.status = STATUS_EMPTY;
          empty_seen++;
        end else begin
          res.result_value = sorted_slots[0];
          if (op.kind == KIND_DEQ) begin
            for (int i = 1; i < held_count; i++) sorted_slots[i-1] = sorted_slots[i];
            held_count--;
          end
        end
      end
      default: ;
    endcase
    res.count = CNT_W'(held_count);
    return res;
  endfunction

  // Compare one received result against the oldest prediction.
  task automatic check_result(input out_item_t got);
    out_item_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      $error("unexpected result: value %0d status %0d count %0d",
             got.result_value, got.status, got.count);
      error_count++;
    end else begin
      want = pending_results.pop_front();
      if (got.result_value !== want.result_value) begin
        $error("result_value: expected %0d, got %0d", want.result_value, got.result_value);
        error_count++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        error_count++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        error_count++;
      end
    end
  endtask

  // Output side: check each accepted transaction, then choose the next stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result(out_data_o);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (holds_done != holds_asked) begin
      // A long hold-off lets the queue back up and stall its input.
      holds_done <= holds_done + 1;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: the run ends if no transaction moves on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one operation, possibly after a random gap, and predict it once accepted.
  task automatic send_op(input logic [KIND_W-1:0] kind, input logic signed [DATA_W-1:0] value);
    in_item_t op;
    op = '{kind: kind, value: value};
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      in_data_i <= in_item_t'({$urandom(), $urandom()});
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= op;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(apply_queue_op(op));
    ops_sent++;
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Two-phase register write; the register takes the data at the access edge.
  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == CAP_ADDR) capacity_reg = data[CAP_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Read the capacity register back and compare it with the last write.
  task automatic check_capacity_readback();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= CAP_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[CAP_W-1:0] !== capacity_reg) begin
      $error("capacity_in_use: expected %0d, got %0d", capacity_reg, prdata[CAP_W-1:0]);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Set the capacity with random upper bits, which the register must discard.
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    logic [PDATA_W-1:0] word;
    word = $urandom();
    word[CAP_W-1:0] = cap;
    write_reg(CAP_ADDR, word);
    check_capacity_readback();
  endtask

  // Values mixing the full range, a narrow band full of ties, a wider band around zero, and the extremes.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6:    return $signed(DATA_W'($urandom_range(8))) - 4;
      7:          return {1'b0, {(DATA_W-1){1'b1}}};
      8:          return {1'b1, {(DATA_W-1){1'b0}}};
      default:    return $signed(DATA_W'($urandom_range(2000))) - 1000;
    endcase
  endfunction

  // Reads on an empty queue.
  task automatic test_empty_reads();
    send_op(KIND_PEEK, 32'sd7);
    send_op(KIND_DEQ, -32'sd7);
    send_op(KIND_UNUSED, 32'sd1);
    wait_for_drain();
  endtask

  // Extreme values, ties and ascending departure order.
  task automatic test_value_order();
    send_op(KIND_ENQ, {1'b0, {(DATA_W-1){1'b1}}});
    send_op(KIND_ENQ, {1'b1, {(DATA_W-1){1'b0}}});
    send_op(KIND_ENQ, 32'sd0);
    send_op(KIND_ENQ, -32'sd1);
    send_op(KIND_ENQ, -32'sd1);
    send_op(KIND_PEEK, 32'sd0);
    send_op(KIND_UNUSED, 32'sd5);
    repeat (5) send_op(KIND_DEQ, 32'sd0);
    send_op(KIND_DEQ, 32'sd0);
    wait_for_drain();
  endtask

  // Full queue, capacity dropped under the count, zero and saturating capacity,
  // and a write to an address with no register.
  task automatic test_capacity_limits();
    set_capacity(CAP_W'(2));
    send_op(KIND_ENQ, 32'sd3);
    send_op(KIND_ENQ, 32'sd1);
    send_op(KIND_ENQ, 32'sd2);
    wait_for_drain();
    set_capacity(CAP_W'(1));
    send_op(KIND_ENQ, 32'sd9);
    send_op(KIND_DEQ, 32'sd0);
    send_op(KIND_ENQ, 32'sd9);
    send_op(KIND_DEQ, 32'sd0);
    send_op(KIND_ENQ, 32'sd9);
    wait_for_drain();
    set_capacity(CAP_W'(0));
    send_op(KIND_ENQ, 32'sd4);
    send_op(KIND_DEQ, 32'sd0);
    wait_for_drain();
    write_reg(UNUSED_ADDR, 32'd5);
    check_capacity_readback();
    set_capacity(CAP_W'(31));
  endtask

  // Random traffic in chunks, each under its own capacity, leaning toward
  // filling or draining in turn so the queue visits both full and empty.
  task automatic test_random_traffic(input int chunks, input int send_pct, input int stall_pct);
    int   lean_enq;
    int   r;
    logic [CAP_W-1:0] cap;
    sender_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    for (int c = 0; c < chunks; c++) begin
      wait_for_drain();
      case (c % 4)
        0:       cap = CAP_W'($urandom_range(1, 15));
        1:       cap = CAP_W'(DEPTH);
        2:       cap = CAP_W'(31);
        default: cap = CAP_W'($urandom_range(0, 4));
      endcase
      set_capacity(cap);
      lean_enq = 60;
      for (int i = 0; i < CHUNK_ITEMS; i++) begin
        if (i % 20 == 0) lean_enq = (lean_enq == 60) ? 25 : 60;
        r = $urandom_range(99);
        if (r < 4) send_op(KIND_UNUSED, pick_value());
        else if (r < 4 + lean_enq) send_op(KIND_ENQ, pick_value());
        else if (r < 88) send_op(KIND_DEQ, pick_value());
        else send_op(KIND_PEEK, pick_value());
      end
    end
  endtask

  // Long output hold-off while the sender keeps offering, then a pause to drain.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    wait_for_drain();
    set_capacity(CAP_W'(DEPTH));
    holds_asked++;
    for (int i = 0; i < FLOOD_ITEMS; i++) begin
      send_op((i % 3 == 2) ? KIND_DEQ : KIND_ENQ, pick_value());
    end
    wait_for_drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    held_count = 0;
    capacity_reg = CAP_RESET;
    error_count = 0;
    ops_sent = 0;
    results_seen = 0;
    full_seen = 0;
    empty_seen = 0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    holds_asked = 0;
    holds_done = 0;
    hold_left = 0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    check_capacity_readback();
    test_empty_reads();
    test_value_order();
    test_capacity_limits();
    test_random_traffic(4, 16, 58);
    test_backpressure();
    test_random_traffic(4, 58, 16);
    test_random_traffic(4, 0, 0);

    // Let any stray result show up before the verdict.
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d operations and checked %0d results across capacities 0 to 31,",
             ops_sent, results_seen);
    $display("with %0d full drops and %0d empty reads under random and long stalls.",
             full_seen, empty_seen);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/spq_pkg.sv
rtl/core/spq_ram.sv
rtl/core/spq_cfg.sv
rtl/core/spq_ctrl.sv
rtl/core/sorted_priority_queue.sv
sim/sorted_priority_queue_tb.sv
